// ----- hw/rtl/hrwc_pkg.sv -----
// hrwc_pkg: shared types and constants for the heap region write checker.
// Holds the command, verdict and register codes and the structs passed between
// the config block, the region cells and the top level. No dependencies.
package hrwc_pkg;

    localparam int REGION_ENTRIES = 64;
    localparam int ADDR_BITS      = 48;
    localparam int CNT_W          = $clog2(REGION_ENTRIES + 1);

    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 5;
    localparam int REG_IDX_W  = 2;

    localparam logic [ADDR_BITS-1:0] STACK_FLOOR_RESET = ADDR_BITS'(48'h7000_0000_0000);
    localparam logic [3:0]           OPC_CHECKED       = 4'd2;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_ALLOC = 2'd1,
        CMD_FREE  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_WRITE = 2'd1,
        OP_ALLOC = 2'd2,
        OP_FREE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        V_NONE     = 2'd0,
        V_UAF      = 2'd1,
        V_OVERFLOW = 2'd2,
        V_FULL     = 2'd3
    } verdict_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_STATIC_START = 2'd0,
        REG_STATIC_END   = 2'd1,
        REG_STACK_FLOOR  = 2'd2
    } reg_idx_t;

    // Configuration register contents
    typedef struct packed {
        logic [ADDR_BITS-1:0] static_start;
        logic [ADDR_BITS-1:0] static_end;
        logic [ADDR_BITS-1:0] stack_floor;
    } hrwc_cfg_t;

    // Query held steady while the search token walks the chain
    typedef struct packed {
        op_t                  op;
        logic [ADDR_BITS-1:0] addr;
        logic [ADDR_BITS-1:0] size;
    } hrwc_query_t;

    // Search token handed from cell to cell, newest entry first
    typedef struct packed {
        logic active;
        logic found;
        logic allocated;
    } hrwc_tok_t;

endpackage

// ----- hw/rtl/hrwc_cfg.sv -----
// hrwc_cfg: APB-style configuration registers (static range, stack floor).
// Depends on hrwc_pkg for widths, register codes and hrwc_cfg_t.
module hrwc_cfg
    import hrwc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output hrwc_cfg_t             cfg
);

    hrwc_cfg_t cfg_reg;
    reg_idx_t  idx;
    logic      wr;

    assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:3]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.static_start <= '0;
            cfg_reg.static_end   <= '0;
            cfg_reg.stack_floor  <= STACK_FLOOR_RESET;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_STATIC_START: cfg_reg.static_start <= pwdata[ADDR_BITS-1:0];
                REG_STATIC_END:   cfg_reg.static_end   <= pwdata[ADDR_BITS-1:0];
                REG_STACK_FLOOR:  cfg_reg.stack_floor  <= pwdata[ADDR_BITS-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_STATIC_START: prdata = CFG_DATA_W'(cfg_reg.static_start);
            REG_STATIC_END:   prdata = CFG_DATA_W'(cfg_reg.static_end);
            REG_STACK_FLOOR:  prdata = CFG_DATA_W'(cfg_reg.stack_floor);
            default:          prdata = '0;
        endcase
    end

endmodule

// ----- hw/rtl/hrwc_cell.sv -----
// hrwc_cell: one heap region entry plus one stage of the search token chain.
// Depends on hrwc_pkg for hrwc_query_t and hrwc_tok_t.
module hrwc_cell
    import hrwc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  hrwc_query_t query,
    input  logic        ins_en,
    input  hrwc_tok_t   tok_in,
    output hrwc_tok_t   tok_out
);

    logic [ADDR_BITS-1:0] base_reg;
    logic [ADDR_BITS-1:0] size_reg;
    logic                 live_reg;
    logic                 alloc_reg;
    hrwc_tok_t            tok_reg;
    hrwc_tok_t            tok_next;

    logic [ADDR_BITS-1:0] offset;
    logic                 covers;
    logic                 match;
    logic                 hit;

    // covers: base <= a and a - base < size, no wrap
    assign offset = query.addr - base_reg;
    assign covers = (query.addr >= base_reg) && (offset < size_reg);

    always_comb
    begin
        case (query.op) inside
            OP_WRITE:          match = covers;
            OP_ALLOC, OP_FREE: match = (base_reg == query.addr);
            default:           match = 1'b0;
        endcase
    end

    // first hit seen on the way down is the newest one
    assign hit = tok_in.active && !tok_in.found && live_reg && match;

    always_comb
    begin
        tok_next.active    = tok_in.active;
        tok_next.found     = tok_in.found || hit;
        tok_next.allocated = hit ? alloc_reg : tok_in.allocated;
    end

    assign tok_out = tok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg   <= '0;
            live_reg  <= 1'b0;
            alloc_reg <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (ins_en)
            begin
                live_reg  <= 1'b1;
                alloc_reg <= 1'b1;
            end
            else if (hit && query.op == OP_ALLOC)
                alloc_reg <= 1'b1;
            else if (hit && query.op == OP_FREE)
                alloc_reg <= 1'b0;
        end
    end

    // entry payload, only read while live
    always_ff @(posedge clk)
    begin
        if (ins_en)
        begin
            base_reg <= query.addr;
            size_reg <= query.size;
        end
        else if (hit && query.op == OP_ALLOC)
            size_reg <= query.size;
    end

endmodule

// ----- hw/rtl/heap_region_write_checker_unit.sv -----
// heap_region_write_checker_unit: top level of the heap region write checker.
// The search token walks the 64-cell region chain one cell per cycle, newest entry first;
// the result register is written in FIN once the output is free. No new beat is taken
// (in_stall high) until the controller is back in IDLE.
// Reset (rst_n, async, low): table empty, config to defaults, no beat pending.
// Depends on hrwc_pkg, hrwc_cfg and hrwc_cell.
module heap_region_write_checker_unit
    import hrwc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // config port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    // input channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            cmd,
    input  logic [ADDR_BITS-1:0]  address,
    input  logic [ADDR_BITS-1:0]  alloc_size,
    input  logic [3:0]            operand_count,
    input  logic [ADDR_BITS-1:0]  instr_address,
    // output channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            verdict,
    output logic [ADDR_BITS-1:0]  report_address,
    output logic [ADDR_BITS-1:0]  report_instr
);

    // Controller: IDLE takes a beat, RUN waits for the token to leave cell 0,
    // FIN writes the result register (and inserts a new entry) once it is free.
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    hrwc_cfg_t            cfg;
    hrwc_query_t          query_reg;
    logic [ADDR_BITS-1:0] instr_reg;
    hrwc_tok_t            tok_in_reg;
    logic                 found_reg;
    logic                 hit_alloc_reg;
    logic [CNT_W-1:0]     count_reg;

    logic                 out_valid_reg;
    verdict_t             verdict_reg;
    logic [ADDR_BITS-1:0] rep_addr_reg;
    logic [ADDR_BITS-1:0] rep_instr_reg;

    hrwc_tok_t            tok [REGION_ENTRIES:0];
    hrwc_query_t          query_next;
    logic                 accept;
    logic                 out_free;
    logic                 finish;
    logic                 table_full;
    logic                 ins_go;
    logic                 static_hit;
    logic                 above_stack;
    verdict_t             verdict_next;

    hrwc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign finish   = (state_reg == ST_FIN) && out_free;

    // Decode the beat into a chain operation. Unchecked writes, alloc of base
    // zero and the spare command code never match any cell.
    always_comb
    begin
        query_next.addr = address;
        query_next.size = alloc_size;
        case (cmd_t'(cmd))
            CMD_WRITE: query_next.op = (operand_count == OPC_CHECKED) ? OP_WRITE : OP_NONE;
            CMD_ALLOC: query_next.op = (address != '0) ? OP_ALLOC : OP_NONE;
            CMD_FREE:  query_next.op = OP_FREE;
            default:   query_next.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            query_reg <= query_next;
            instr_reg <= instr_address;
        end
        if (state_reg == ST_RUN && tok[0].active)
        begin
            found_reg     <= tok[0].found;
            hit_alloc_reg <= tok[0].allocated;
        end
    end

    // Region chain: token enters at the newest end (top cell) and moves down.
    assign tok[REGION_ENTRIES] = tok_in_reg;

    assign table_full = (count_reg == CNT_W'(REGION_ENTRIES));
    assign ins_go     = finish && query_reg.op == OP_ALLOC && !found_reg && !table_full;

    for (genvar i = 0; i < REGION_ENTRIES; i++)
    begin : g_cell
        hrwc_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .query   (query_reg),
            .ins_en  (ins_go && count_reg == CNT_W'(i)),
            .tok_in  (tok[i+1]),
            .tok_out (tok[i])
        );
    end

    // Classification of the finished search
    assign static_hit  = (query_reg.addr >= cfg.static_start) &&
                         (query_reg.addr < cfg.static_end);
    assign above_stack = (query_reg.addr > cfg.stack_floor);

    always_comb
    begin
        verdict_next = V_NONE;
        case (query_reg.op)
            OP_WRITE:
            begin
                if (static_hit)
                    verdict_next = V_NONE;
                else if (found_reg)
                    verdict_next = hit_alloc_reg ? V_NONE : V_UAF;
                else if (above_stack)
                    verdict_next = V_NONE;
                else
                    verdict_next = V_OVERFLOW;
            end
            OP_ALLOC:
                verdict_next = (!found_reg && table_full) ? V_FULL : V_NONE;
            default:
                verdict_next = V_NONE;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_RUN;
            ST_RUN:  if (tok[0].active) state_next = ST_FIN;
            ST_FIN:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tok_in_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            tok_in_reg.active <= accept;
            tok_in_reg.found  <= 1'b0;
            tok_in_reg.allocated <= 1'b0;
            if (ins_go)
                count_reg <= count_reg + CNT_W'(1);
            if (finish)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // result beat payload; zeroed fields when nothing is reported
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            verdict_reg   <= verdict_next;
            rep_addr_reg  <= (verdict_next != V_NONE) ? query_reg.addr : '0;
            rep_instr_reg <= (verdict_next == V_UAF || verdict_next == V_OVERFLOW) ?
                             instr_reg : '0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign verdict        = verdict_reg;
    assign report_address = rep_addr_reg;
    assign report_instr   = rep_instr_reg;

endmodule
